// File: rtl/core/owsm_pkg.sv
// shared types and constants for the omni wheel speed mixer
package owsm_pkg;

  localparam int unsigned NUM_WHEELS  = 4;
  localparam int unsigned MAG_W       = 63;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned DIV_STEPS   = 31;
  localparam int unsigned KIN_STAGES  = 6;
  localparam int unsigned NORM_STAGES = DIV_STEPS + 4;
  localparam int unsigned PIPE_DEPTH  = KIN_STAGES + NORM_STAGES;
  localparam int unsigned CFG_AW      = 4;

  localparam int WHL_LF = 0;
  localparam int WHL_RF = 1;
  localparam int WHL_LB = 2;
  localparam int WHL_RB = 3;

  // 2 * 0.707 in Q1.15
  localparam logic [15:0] LIN_GAIN = 16'd46334;
  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] REG_ROT_ARM = 2'd0;
  localparam logic [1:0] REG_INV_RAD = 2'd1;
  localparam logic [1:0] REG_MAX_SPD = 2'd2;

  typedef struct packed {
    logic [31:0] rotation_arm;
    logic [31:0] inv_wheel_radius;
    logic [14:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
  } mag_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] rem;
    logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
    logic [MAG_W-1:0]                 peak;
    logic                             scaled;
  } div_t;

  typedef struct packed {
    logic [31:0] left_front;
    logic [31:0] right_front;
    logic [31:0] left_back;
    logic [31:0] right_back;
    logic        was_scaled;
  } res_t;

endpackage

// File: rtl/core/owsm_ifs.sv
// velocity and wheel speed channel interfaces
interface owsm_vel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;

  modport source (output valid, vel_x, vel_y, yaw_rate, input ready);
  modport sink (input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface owsm_whl_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_front;
  logic signed [31:0] right_front;
  logic signed [31:0] left_back;
  logic signed [31:0] right_back;
  logic               was_scaled;

  modport source (output valid, left_front, right_front, left_back, right_back, was_scaled,
                  input ready);
  modport sink (input valid, left_front, right_front, left_back, right_back, was_scaled,
                output ready);
endinterface

// File: rtl/core/omni_wheel_speed_mixer.sv
// top level of the four wheel omni speed mixer
//
// in_if carries one velocity word (vel_x, vel_y, yaw_rate, signed q16.16) per
// valid/ready handshake; out_if returns one word of four signed q16.16 wheel
// speeds plus was_scaled for every accepted input, in order.
// the apb port (psel .. pready) holds rotation_arm at 0x0, inv_wheel_radius at
// 0x4 and max_speed at 0x8; write them only while no words are in flight.
// throughput: one word per clock while out_if.ready stays high.
// pipeline stages from input handshake to out_if.valid:
// 6 stages of kinematics and multiplies, 2 of peak search, 1 limit compare,
// 31 divider steps (one quotient bit each), 1 sign stage, 1 output register.
// reset clears every valid bit and loads the registers with 65536, 65536
// and 8000.
// when out_if.ready is low the output register and a skid entry absorb the
// next word, then in_if.ready drops and the whole pipeline holds in place;
// nothing is dropped or repeated.
module omni_wheel_speed_mixer import owsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  owsm_vel_if.sink          in_if,
  owsm_whl_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic pipe_en;
  logic kin_valid, norm_valid;
  mag_t kin_data;
  res_t norm_data, out_word;

  owsm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_if.ready = pipe_en;

  owsm_kin u_kin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_if.valid),
    .vel_x     (in_if.vel_x),
    .vel_y     (in_if.vel_y),
    .yaw_rate  (in_if.yaw_rate),
    .cfg       (cfg),
    .out_valid (kin_valid),
    .out_data  (kin_data)
  );

  owsm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (kin_valid),
    .in_data   (kin_data),
    .max_speed (cfg.max_speed),
    .out_valid (norm_valid),
    .out_data  (norm_data)
  );

  owsm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (norm_valid),
    .up_data   (norm_data),
    .up_ready  (pipe_en),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_word)
  );

  assign out_if.left_front  = out_word.left_front;
  assign out_if.right_front = out_word.right_front;
  assign out_if.left_back   = out_word.left_back;
  assign out_if.right_back  = out_word.right_back;
  assign out_if.was_scaled  = out_word.was_scaled;

endmodule

// File: rtl/core/owsm_regs.sv
// apb configuration registers
module owsm_regs import owsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation_arm     <= 32'd65536;
      cfg_r.inv_wheel_radius <= 32'd65536;
      cfg_r.max_speed        <= 15'd8000;
    end else if (wr) begin
      case (paddr[3:2])
        REG_ROT_ARM: cfg_r.rotation_arm     <= pwdata;
        REG_INV_RAD: cfg_r.inv_wheel_radius <= pwdata;
        REG_MAX_SPD: cfg_r.max_speed        <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROT_ARM: prdata = cfg_r.rotation_arm;
      REG_INV_RAD: prdata = cfg_r.inv_wheel_radius;
      REG_MAX_SPD: prdata = {17'd0, cfg_r.max_speed};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/owsm_kin.sv
// inverse kinematics pipeline: body velocity to wheel speed magnitudes
module owsm_kin import owsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] yaw_rate,
  input  cfg_t               cfg,
  output logic               out_valid,
  output mag_t               out_data
);

  logic [KIN_STAGES-1:0] v_r;

  logic signed [48:0] lx_nxt, ly_nxt, lx_r, ly_r;
  logic signed [64:0] yaw_full;
  logic signed [63:0] yaw_r, yaw2_r;

  logic signed [49:0] lin_nxt [NUM_WHEELS];
  logic signed [49:0] lin_r   [NUM_WHEELS];

  logic signed [65:0] sum_w   [NUM_WHEELS];
  logic signed [63:0] s_nxt   [NUM_WHEELS];
  logic signed [63:0] s_r     [NUM_WHEELS];

  logic [63:0]        abs_w   [NUM_WHEELS];
  logic [MAG_W-1:0]   m_nxt   [NUM_WHEELS];
  logic [MAG_W-1:0]   m_r     [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg_nxt, neg4_r, neg5_r, neg6_r;

  logic [62:0]        ph_nxt  [NUM_WHEELS];
  logic [62:0]        ph_r    [NUM_WHEELS];
  logic [63:0]        pl_nxt  [NUM_WHEELS];
  logic [63:0]        pl_r    [NUM_WHEELS];

  logic [MAG_W-1:0]   mag_nxt [NUM_WHEELS];
  logic [MAG_W-1:0]   mag_r   [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[KIN_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = v_r[KIN_STAGES-1];

  // stage 1: products
  assign lx_nxt   = vel_x * $signed({1'b0, LIN_GAIN});
  assign ly_nxt   = vel_y * $signed({1'b0, LIN_GAIN});
  assign yaw_full = yaw_rate * $signed({1'b0, cfg.rotation_arm});

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      yaw_r <= yaw_full[63:0];
    end
  end

  // stage 2: linear mix per wheel
  always_comb begin
    lin_nxt[WHL_LF] = 50'(ly_r) - 50'(lx_r);
    lin_nxt[WHL_RF] = 50'(lx_r) + 50'(ly_r);
    lin_nxt[WHL_LB] = -50'(lx_r) - 50'(ly_r);
    lin_nxt[WHL_RB] = 50'(lx_r) - 50'(ly_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r  <= lin_nxt;
      yaw2_r <= yaw_r;
    end
  end

  // stage 3: saturating sum
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum_w[i] = 66'(yaw2_r) + 66'(lin_r[i]);
      if (!sum_w[i][65] && sum_w[i][64:63] != 2'b00) begin
        s_nxt[i] = S_MAX;
      end else if (sum_w[i][65] && (sum_w[i][64:63] != 2'b11 || sum_w[i][62:0] == '0)) begin
        s_nxt[i] = -S_MAX;
      end else begin
        s_nxt[i] = sum_w[i][63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  // stage 4: magnitude and sign
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      neg_nxt[i] = s_r[i][63];
      abs_w[i]   = s_r[i][63] ? 64'(-s_r[i]) : 64'(s_r[i]);
      m_nxt[i]   = abs_w[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      neg4_r <= neg_nxt;
    end
  end

  // stage 5: partial products with the reciprocal radius
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      ph_nxt[i] = 63'(m_r[i][62:32]) * 63'(cfg.inv_wheel_radius);
      pl_nxt[i] = 64'(m_r[i][31:0]) * 64'(cfg.inv_wheel_radius);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      neg5_r <= neg4_r;
    end
  end

  // stage 6: combine to q47.16 magnitude
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag_nxt[i] = ph_r[i] + 63'(pl_r[i][63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      neg6_r <= neg5_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      out_data.mag[i] = mag_r[i];
    end
    out_data.neg = neg6_r;
  end

endmodule

// File: rtl/core/owsm_div_stage.sv
// one restoring step of the pipelined ratio divider
module owsm_div_stage import owsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  input  logic t_bit,
  output logic out_valid,
  output div_t out_data
);

  logic             valid_r;
  div_t             data_r;
  div_t             data_nxt;
  logic [MAG_W-1:0] wsel [NUM_WHEELS];
  logic [65:0]      acc  [NUM_WHEELS];
  logic [65:0]      d1   [NUM_WHEELS];
  logic [65:0]      d2   [NUM_WHEELS];
  logic [QUO_W-1:0] qs   [NUM_WHEELS];

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      wsel[i] = t_bit ? in_data.mag[i] : '0;
      acc[i]  = {2'b00, in_data.rem[i], 1'b0} + 66'(wsel[i]);
      d1[i]   = acc[i] - 66'(in_data.peak);
      d2[i]   = acc[i] - {2'b00, in_data.peak, 1'b0};
      qs[i]   = {in_data.quo[i][QUO_W-2:0], 1'b0};
      if (!d2[i][65]) begin
        data_nxt.rem[i] = d2[i][MAG_W-1:0];
        data_nxt.quo[i] = qs[i] + QUO_W'(2);
      end else if (!d1[i][65]) begin
        data_nxt.rem[i] = d1[i][MAG_W-1:0];
        data_nxt.quo[i] = qs[i] + QUO_W'(1);
      end else begin
        data_nxt.rem[i] = acc[i][MAG_W-1:0];
        data_nxt.quo[i] = qs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/core/owsm_norm.sv
// peak search, proportional scaling and sign restore
module owsm_norm import owsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  mag_t        in_data,
  input  logic [14:0] max_speed,
  output logic        out_valid,
  output res_t        out_data
);

  logic             v1_r, v2_r, v3_r, vf_r;
  mag_t             d1_r, d2_r;
  logic [MAG_W-1:0] pk_lo_nxt, pk_hi_nxt, pk_lo_r, pk_hi_r;
  logic [MAG_W-1:0] peak_nxt, peak_r;
  logic [QUO_W-1:0] limit;
  div_t             dv0_nxt, dv0_r;

  logic             dv_v [DIV_STEPS+1];
  div_t             dv_d [DIV_STEPS+1];

  logic [31:0]      val_w [NUM_WHEELS];
  logic [31:0]      spd_w [NUM_WHEELS];
  res_t             res_nxt, res_r;

  assign limit = {max_speed, 16'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vf_r <= dv_v[DIV_STEPS];
    end
  end

  // peak over the four wheels, two levels
  assign pk_lo_nxt = (in_data.mag[WHL_LF] > in_data.mag[WHL_RF]) ?
                     in_data.mag[WHL_LF] : in_data.mag[WHL_RF];
  assign pk_hi_nxt = (in_data.mag[WHL_LB] > in_data.mag[WHL_RB]) ?
                     in_data.mag[WHL_LB] : in_data.mag[WHL_RB];
  assign peak_nxt  = (pk_lo_r > pk_hi_r) ? pk_lo_r : pk_hi_r;

  always_comb begin
    dv0_nxt.mag    = d2_r.mag;
    dv0_nxt.neg    = d2_r.neg;
    dv0_nxt.rem    = '0;
    dv0_nxt.quo    = '0;
    dv0_nxt.peak   = peak_r;
    dv0_nxt.scaled = peak_r > MAG_W'(limit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= in_data;
      pk_lo_r <= pk_lo_nxt;
      pk_hi_r <= pk_hi_nxt;
      d2_r    <= d1_r;
      peak_r  <= peak_nxt;
      dv0_r   <= dv0_nxt;
    end
  end

  assign dv_v[0] = v3_r;
  assign dv_d[0] = dv0_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    owsm_div_stage u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_data   (dv_d[k]),
      .t_bit     (limit[DIV_STEPS-1-k]),
      .out_valid (dv_v[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // select scaled or raw magnitude and put the sign back
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      val_w[i] = dv_d[DIV_STEPS].scaled ? 32'(dv_d[DIV_STEPS].quo[i])
                                        : dv_d[DIV_STEPS].mag[i][31:0];
      spd_w[i] = dv_d[DIV_STEPS].neg[i] ? (32'd0 - val_w[i]) : val_w[i];
    end
    res_nxt.left_front  = spd_w[WHL_LF];
    res_nxt.right_front = spd_w[WHL_RF];
    res_nxt.left_back   = spd_w[WHL_LB];
    res_nxt.right_back  = spd_w[WHL_RB];
    res_nxt.was_scaled  = dv_d[DIV_STEPS].scaled;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vf_r;
  assign out_data  = res_r;

endmodule

// File: rtl/core/owsm_skid.sv
// two-entry output buffer between the pipeline and the result channel
module owsm_skid import owsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  res_t up_data,
  output logic up_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r, sk_valid_r;
  res_t out_data_r, sk_data_r;
  logic push, pop, load;

  assign up_ready = !sk_valid_r;
  assign push     = up_valid && up_ready;
  assign pop      = out_valid_r && out_ready;
  assign load     = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= sk_valid_r || push;
      end
      if (load && sk_valid_r) begin
        sk_valid_r <= 1'b0;
      end else if (!load && push) begin
        sk_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= sk_valid_r ? sk_data_r : up_data;
    end
    if (!load && push) begin
      sk_data_r <= up_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/owsm_checker.sv
// port-level assertions for the omni wheel speed mixer, bound to the top
module owsm_checker import owsm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] left_front,
  input logic [31:0] right_front,
  input logic [31:0] left_back,
  input logic [31:0] right_back,
  input logic        was_scaled
);

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 3);

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_fire && !out_fire) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (!in_fire && out_fire) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> inflight_r != '0)
    else $error("result word without a pending input word");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(PIPE_DEPTH + 2))
    else $error("more words in flight than the pipeline holds");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_front) &&
      $stable(right_front) && $stable(left_back) && $stable(right_back) &&
      $stable(was_scaled))
    else $error("stalled result word changed or dropped");

endmodule

bind omni_wheel_speed_mixer owsm_checker u_owsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .left_front  (out_if.left_front),
  .right_front (out_if.right_front),
  .left_back   (out_if.left_back),
  .right_back  (out_if.right_back),
  .was_scaled  (out_if.was_scaled)
);

// File: sim/testbench.sv
// self-checking testbench for the omni wheel speed mixer: directed table, then random phases
module testbench import owsm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] LIN_PAIR = 16'd46334;
  localparam logic signed [65:0] SUM_LIM = $signed({3'b000, {63{1'b1}}});
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_PHASES = 8;
  localparam int WORDS_PER_PHASE = 144;
  localparam int TAIL_CYCLES = 60;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [31:0]        value;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
    bit                 typed;
    logic [31:0]        spd;
    bit                 ws;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  owsm_vel_if vel_ch ();
  owsm_whl_if whl_ch ();

  omni_wheel_speed_mixer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (vel_ch),
    .out_if  (whl_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t      reg_shadow;
  res_t      wheel_q[$];
  stim_row_t stim_tbl[$];
  int        errors = 0;
  int        cycles = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_scaled = 0;
  int        n_settings = 0;
  int        stall_left = 0;
  bit        src_idle = 1'b1;
  bit        sink_stall = 1'b1;

  // wheel speeds for one velocity word under the given register values
  function automatic res_t mix_wheels(logic signed [31:0] vx, logic signed [31:0] vy,
                                      logic signed [31:0] wz, cfg_t c);
    logic signed [65:0] lin_x;
    logic signed [65:0] lin_y;
    logic signed [65:0] yaw_t;
    logic signed [65:0] sum;
    logic [62:0]        mag [NUM_WHEELS];
    logic               neg [NUM_WHEELS];
    logic [31:0]        spd [NUM_WHEELS];
    logic [95:0]        prod;
    logic [94:0]        quo;
    logic [62:0]        peak;
    logic [31:0]        limit;
    logic               scaled;
    res_t               r;
    lin_x = vx * $signed({1'b0, LIN_PAIR});
    lin_y = vy * $signed({1'b0, LIN_PAIR});
    yaw_t = wz * $signed({1'b0, c.rotation_arm});
    peak = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum = yaw_t + ((i == WHL_LF || i == WHL_LB) ? -lin_x : lin_x)
                  + ((i == WHL_LB || i == WHL_RB) ? -lin_y : lin_y);
      if (sum > SUM_LIM) begin
        sum = SUM_LIM;
      end else if (sum < -SUM_LIM) begin
        sum = -SUM_LIM;
      end
      neg[i] = sum < 0;
      if (neg[i]) begin
        sum = -sum;
      end
      prod = sum[62:0] * c.inv_wheel_radius;
      mag[i] = prod[94:32];
      if (mag[i] > peak) begin
        peak = mag[i];
      end
    end
    limit = {1'b0, c.max_speed, 16'h0000};
    scaled = peak > limit;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (scaled) begin
        quo = (mag[i] * limit) / peak;
        spd[i] = quo[31:0];
      end else begin
        spd[i] = mag[i][31:0];
      end
      if (neg[i]) begin
        spd[i] = -spd[i];
      end
    end
    r.left_front  = spd[WHL_LF];
    r.right_front = spd[WHL_RF];
    r.left_back   = spd[WHL_LB];
    r.right_back  = spd[WHL_RB];
    r.was_scaled  = scaled;
    return r;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      4, 5: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      6: return $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return $urandom_range(0, 1);
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_reg32();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3, 4: return $urandom_range(1, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return 32'd32767;
      2: return 32'd0;
      3, 4: return 32'd8000;
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic row_cfg(logic [1:0] idx, logic [31:0] value);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.value = value;
    row.vx = '0;
    row.vy = '0;
    row.wz = '0;
    row.typed = 1'b0;
    row.spd = '0;
    row.ws = 1'b0;
    stim_tbl.push_back(row);
  endtask

  task automatic row_word(logic [31:0] vx, logic [31:0] vy, logic [31:0] wz);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.idx = REG_ROT_ARM;
    row.value = '0;
    row.vx = vx;
    row.vy = vy;
    row.wz = wz;
    row.typed = 1'b0;
    row.spd = '0;
    row.ws = 1'b0;
    stim_tbl.push_back(row);
  endtask

  // all four wheels share one expected speed in these rows
  task automatic row_typed(logic [31:0] vx, logic [31:0] vy, logic [31:0] wz,
                           logic [31:0] spd, bit ws);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.idx = REG_ROT_ARM;
    row.value = '0;
    row.vx = vx;
    row.vy = vy;
    row.wz = wz;
    row.typed = 1'b1;
    row.spd = spd;
    row.ws = ws;
    stim_tbl.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROT_ARM: begin
        reg_shadow.rotation_arm = value;
        want = value;
      end
      REG_INV_RAD: begin
        reg_shadow.inv_wheel_radius = value;
        want = value;
      end
      default: begin
        reg_shadow.max_speed = value[14:0];
        want = {17'b0, value[14:0]};
      end
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report("register read back", prdata, want);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_word(logic [31:0] vx, logic [31:0] vy, logic [31:0] wz,
                           bit typed, res_t want);
    int gap;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      vel_ch.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    vel_ch.valid <= 1'b1;
    vel_ch.vel_x <= vx;
    vel_ch.vel_y <= vy;
    vel_ch.yaw_rate <= wz;
    do @(posedge clk); while (!vel_ch.ready);
    wheel_q.push_back(typed ? want : mix_wheels(vx, vy, wz, reg_shadow));
    n_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every wheel word is back
  task automatic drain();
    vel_ch.valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] arm, logic [31:0] inv, logic [31:0] lim);
    drain();
    write_reg(REG_ROT_ARM, arm);
    write_reg(REG_INV_RAD, inv);
    write_reg(REG_MAX_SPD, lim);
    n_settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d wheel words outstanding", wheel_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      whl_ch.ready <= 1'b0;
    end else if (sink_stall && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      whl_ch.ready <= 1'b0;
    end else begin
      whl_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && whl_ch.valid && whl_ch.ready) begin
      got.left_front  = whl_ch.left_front;
      got.right_front = whl_ch.right_front;
      got.left_back   = whl_ch.left_back;
      got.right_back  = whl_ch.right_back;
      got.was_scaled  = whl_ch.was_scaled;
      if (wheel_q.size() == 0) begin
        report("unexpected wheel word", got.left_front, 32'h0);
      end else begin
        want = wheel_q.pop_front();
        n_checked++;
        if (want.was_scaled) begin
          n_scaled++;
        end
        if (got.left_front !== want.left_front) begin
          report("left_front", got.left_front, want.left_front);
        end
        if (got.right_front !== want.right_front) begin
          report("right_front", got.right_front, want.right_front);
        end
        if (got.left_back !== want.left_back) begin
          report("left_back", got.left_back, want.left_back);
        end
        if (got.right_back !== want.right_back) begin
          report("right_back", got.right_back, want.right_back);
        end
        if (got.was_scaled !== want.was_scaled) begin
          report("was_scaled", {31'b0, got.was_scaled}, {31'b0, want.was_scaled});
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vel_ch.valid = 1'b0;
    vel_ch.vel_x = '0;
    vel_ch.vel_y = '0;
    vel_ch.yaw_rate = '0;
    whl_ch.ready = 1'b0;
    reg_shadow.rotation_arm = 32'h0001_0000;
    reg_shadow.inv_wheel_radius = 32'h0001_0000;
    reg_shadow.max_speed = 15'd8000;

    // reset values: unit arm, unit radius, limit 8000
    row_typed(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    row_typed(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    row_typed(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
    row_word(32'h0001_0000, 32'h0, 32'h0);
    row_word(32'h0, 32'hFFFF_0000, 32'h0);
    row_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    row_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    row_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    row_typed(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1F40_0000, 1'b1);
    row_typed(32'h0, 32'h0, 32'h8000_0000, 32'hE0C0_0000, 1'b1);
    // peak right at the limit, then one lsb over
    row_typed(32'h0, 32'h0, 32'h1F40_0000, 32'h1F40_0000, 1'b0);
    row_typed(32'h0, 32'h0, 32'h1F40_0001, 32'h1F40_0000, 1'b1);
    // largest arm and radius: the sum saturates
    row_cfg(REG_ROT_ARM, 32'hFFFF_FFFF);
    row_cfg(REG_INV_RAD, 32'hFFFF_FFFF);
    row_cfg(REG_MAX_SPD, 32'd32767);
    row_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    row_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    row_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    // zero limit scales every nonzero word to zero
    row_cfg(REG_MAX_SPD, 32'd0);
    row_typed(32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1);
    row_typed(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    row_cfg(REG_ROT_ARM, 32'h0);
    row_cfg(REG_INV_RAD, 32'h0);
    row_cfg(REG_MAX_SPD, 32'd1);
    row_typed(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_tbl[n]) begin
      if (stim_tbl[n].kind == ROW_CFG) begin
        drain();
        write_reg(stim_tbl[n].idx, stim_tbl[n].value);
        n_settings++;
      end else begin
        send_word(stim_tbl[n].vx, stim_tbl[n].vy, stim_tbl[n].wz, stim_tbl[n].typed,
                  '{left_front: stim_tbl[n].spd, right_front: stim_tbl[n].spd,
                    left_back: stim_tbl[n].spd, right_back: stim_tbl[n].spd,
                    was_scaled: stim_tbl[n].ws});
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        set_regs(32'hFFFF_FFFF, 32'h0000_0001, 32'd32767);
      end else if (ph == 1) begin
        set_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'd1);
      end else if (ph == RAND_PHASES - 1) begin
        set_regs(32'h0001_0000, 32'h0001_0000, 32'd8000);
      end else begin
        set_regs(rand_reg32(), rand_reg32(), rand_limit());
      end
      src_idle = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_stall = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (WORDS_PER_PHASE) begin
        send_word(rand_vel(), rand_vel(), rand_vel(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d velocity words over %0d register settings, %0d wheel words checked",
             n_sent, n_settings, n_checked);
    $display("%0d words hit the speed limit and were scaled", n_scaled);
    if (errors == 0 && wheel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d wheel words never arrived", errors, wheel_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/owsm_pkg.sv
rtl/core/owsm_ifs.sv
rtl/core/owsm_regs.sv
rtl/core/owsm_kin.sv
rtl/core/owsm_div_stage.sv
rtl/core/owsm_norm.sv
rtl/core/owsm_skid.sv
rtl/core/omni_wheel_speed_mixer.sv
rtl/core/owsm_checker.sv
sim/testbench.sv
